/* src/prdc_pkg.sv */
package prdc_pkg;

  localparam int COORD_BITS = 24;
  localparam int CNT_BITS   = 16;
  localparam int LIMIT_BITS = 50;
  localparam int AREA_BITS  = 64;

  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int SQ_BITS    = 2 * COORD_BITS;
  localparam int LEN_BITS   = SQ_BITS + 1;
  localparam int CMP_BITS   = (LEN_BITS > LIMIT_BITS) ? LEN_BITS : LIMIT_BITS;
  localparam int PROD_BITS  = 2 * COORD_BITS;
  localparam int CROSS_BITS = PROD_BITS + 1;
  localparam int ESUM_BITS  = CROSS_BITS + 1;

  localparam int IN_DATA_BITS    = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int USER_BITS       = 2;
  localparam int USER_EMPTY      = 0;
  localparam int USER_LAST_POLY  = 1;
  localparam int OUT_FIELDS_BITS = 5 * CNT_BITS + 1;
  localparam int OUT_DATA_BITS   = ((OUT_FIELDS_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_BITS    = OUT_DATA_BITS - OUT_FIELDS_BITS;

  localparam int CFG_DATA_BITS = 64;
  localparam int CFG_ADDR_BITS = 4;
  localparam logic REG_EDGE_LIMIT = 1'b0;
  localparam logic REG_AREA_LIMIT = 1'b1;

  localparam logic [1:0] VCOUNT_SAT = 2'd3;
  localparam logic [1:0] VCOUNT_TWO = 2'd2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [CROSS_BITS-1:0] cross_t;
  typedef logic signed [ESUM_BITS-1:0]  esum_t;
  typedef logic [CNT_BITS-1:0]          cnt_t;
  typedef logic [LIMIT_BITS-1:0]        limit_t;
  typedef logic [AREA_BITS-1:0]         area_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  // intake stage: an item carries the new edge and the closing edge, each with its own enable
  typedef struct packed {
    point_t e1a;
    point_t e1b;
    point_t e2a;
    point_t e2b;
    logic   e1_en;
    logic   e2_en;
    logic   ends;
    logic   last_poly;
    logic   ge3;
  } s1_t;

  typedef struct packed {
    logic [SQ_BITS-1:0] sq_x1;
    logic [SQ_BITS-1:0] sq_y1;
    logic [SQ_BITS-1:0] sq_x2;
    logic [SQ_BITS-1:0] sq_y2;
    prod_t              px1;
    prod_t              py1;
    prod_t              px2;
    prod_t              py2;
    logic               dup1;
    logic               dup2;
    logic               e1_en;
    logic               e2_en;
    logic               ends;
    logic               last_poly;
    logic               ge3;
  } s2_t;

  typedef struct packed {
    logic [1:0] dup_inc;
    logic [1:0] zero_inc;
    esum_t      area_d;
    logic       ends;
    logic       last_poly;
    logic       ge3;
  } s3_t;

  typedef struct packed {
    cnt_t  dups;
    cnt_t  zeros;
    area_t area;
    logic  last_poly;
    logic  ge3;
  } ring_t;

endpackage

/* src/prdc_cfg_regs.sv */
module prdc_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [prdc_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [prdc_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic [prdc_pkg::CFG_DATA_BITS-1:0]  prdata,
  output logic                                pready,
  output prdc_pkg::limit_t                    edge_limit,
  output prdc_pkg::limit_t                    area_limit
);

  logic reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[prdc_pkg::CFG_ADDR_BITS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_limit <= '0;
      area_limit <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        prdc_pkg::REG_EDGE_LIMIT: edge_limit <= pwdata[prdc_pkg::LIMIT_BITS-1:0];
        prdc_pkg::REG_AREA_LIMIT: area_limit <= pwdata[prdc_pkg::LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      prdc_pkg::REG_EDGE_LIMIT: prdata = prdc_pkg::CFG_DATA_BITS'(edge_limit);
      prdc_pkg::REG_AREA_LIMIT: prdata = prdc_pkg::CFG_DATA_BITS'(area_limit);
      default:                  prdata = '0;
    endcase
  end

endmodule

/* src/prdc_front.sv */
module prdc_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [COORD_BITS-1:0] vertex_x, [2*COORD_BITS-1:COORD_BITS] vertex_y
  input  logic [prdc_pkg::IN_DATA_BITS-1:0]  s_tdata,
  input  logic                               s_tlast,
  // [0] empty_ring, [1] last_in_polygon
  input  logic [prdc_pkg::USER_BITS-1:0]     s_tuser,
  input  logic                               nxt_free,
  output logic                               out_v,
  output prdc_pkg::s1_t                      out_d
);

  prdc_pkg::point_t prev;
  prdc_pkg::point_t first;
  logic [1:0]       count;

  prdc_pkg::point_t cur;
  prdc_pkg::point_t prev_after;
  prdc_pkg::point_t first_after;
  logic [1:0]       cnt_after;
  logic             empty;
  logic             ends;
  logic             accept;
  prdc_pkg::s1_t    item;

  assign s_tready = !out_v || nxt_free;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    cur.x = s_tdata[prdc_pkg::COORD_BITS-1:0];
    cur.y = s_tdata[2*prdc_pkg::COORD_BITS-1:prdc_pkg::COORD_BITS];
    empty = s_tuser[prdc_pkg::USER_EMPTY];
    if (empty) begin
      prev_after  = prev;
      first_after = first;
      cnt_after   = count;
    end else begin
      prev_after  = cur;
      first_after = (count == 2'd0) ? cur : first;
      cnt_after   = (count == prdc_pkg::VCOUNT_SAT) ? count : count + 2'd1;
    end
    ends           = empty || s_tlast;
    item.e1a       = prev;
    item.e1b       = cur;
    item.e1_en     = !empty && (count != 2'd0);
    item.e2a       = prev_after;
    item.e2b       = first_after;
    item.e2_en     = ends && (cnt_after >= prdc_pkg::VCOUNT_TWO);
    item.ends      = ends;
    item.last_poly = s_tuser[prdc_pkg::USER_LAST_POLY];
    item.ge3       = (cnt_after == prdc_pkg::VCOUNT_SAT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
      prev  <= '0;
      first <= '0;
      count <= '0;
    end else begin
      if (s_tready) begin
        out_v <= s_tvalid;
      end
      if (accept) begin
        if (ends) begin
          prev  <= '0;
          first <= '0;
          count <= '0;
        end else begin
          prev  <= prev_after;
          first <= first_after;
          count <= cnt_after;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_d <= item;
    end
  end

endmodule

/* src/prdc_edge_math.sv */
module prdc_edge_math (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_v,
  input  prdc_pkg::s1_t     in_d,
  output logic              in_free,
  input  prdc_pkg::limit_t  edge_limit,
  input  logic              nxt_free,
  output logic              out_v,
  output prdc_pkg::s3_t     out_d
);

  logic          s2_v;
  prdc_pkg::s2_t s2;
  prdc_pkg::s2_t s2_next;
  prdc_pkg::s3_t s3_next;
  logic          s3_free;

  prdc_pkg::diff_t dx1, dy1, dx2, dy2;
  logic signed [2*prdc_pkg::DIFF_BITS-1:0] qx1, qy1, qx2, qy2;

  logic [prdc_pkg::LEN_BITS-1:0] len1, len2;
  prdc_pkg::cross_t              cr1, cr2;
  logic                          zero1, zero2;

  assign s3_free = !out_v || nxt_free;
  assign in_free = !s2_v || s3_free;

  // squares and cross products of both edges
  always_comb begin
    dx1 = prdc_pkg::diff_t'(in_d.e1b.x) - prdc_pkg::diff_t'(in_d.e1a.x);
    dy1 = prdc_pkg::diff_t'(in_d.e1b.y) - prdc_pkg::diff_t'(in_d.e1a.y);
    dx2 = prdc_pkg::diff_t'(in_d.e2b.x) - prdc_pkg::diff_t'(in_d.e2a.x);
    dy2 = prdc_pkg::diff_t'(in_d.e2b.y) - prdc_pkg::diff_t'(in_d.e2a.y);
    qx1 = dx1 * dx1;
    qy1 = dy1 * dy1;
    qx2 = dx2 * dx2;
    qy2 = dy2 * dy2;
    s2_next.sq_x1     = qx1[prdc_pkg::SQ_BITS-1:0];
    s2_next.sq_y1     = qy1[prdc_pkg::SQ_BITS-1:0];
    s2_next.sq_x2     = qx2[prdc_pkg::SQ_BITS-1:0];
    s2_next.sq_y2     = qy2[prdc_pkg::SQ_BITS-1:0];
    s2_next.px1       = prdc_pkg::prod_t'(in_d.e1a.x) * prdc_pkg::prod_t'(in_d.e1b.y);
    s2_next.py1       = prdc_pkg::prod_t'(in_d.e1b.x) * prdc_pkg::prod_t'(in_d.e1a.y);
    s2_next.px2       = prdc_pkg::prod_t'(in_d.e2a.x) * prdc_pkg::prod_t'(in_d.e2b.y);
    s2_next.py2       = prdc_pkg::prod_t'(in_d.e2b.x) * prdc_pkg::prod_t'(in_d.e2a.y);
    s2_next.dup1      = in_d.e1_en && (in_d.e1a == in_d.e1b);
    s2_next.dup2      = in_d.e2_en && (in_d.e2a == in_d.e2b);
    s2_next.e1_en     = in_d.e1_en;
    s2_next.e2_en     = in_d.e2_en;
    s2_next.ends      = in_d.ends;
    s2_next.last_poly = in_d.last_poly;
    s2_next.ge3       = in_d.ge3;
  end

  // length test and signed area contribution
  always_comb begin
    len1  = {1'b0, s2.sq_x1} + {1'b0, s2.sq_y1};
    len2  = {1'b0, s2.sq_x2} + {1'b0, s2.sq_y2};
    zero1 = s2.e1_en && (prdc_pkg::CMP_BITS'(len1) <= prdc_pkg::CMP_BITS'(edge_limit));
    zero2 = s2.e2_en && (prdc_pkg::CMP_BITS'(len2) <= prdc_pkg::CMP_BITS'(edge_limit));
    cr1   = s2.e1_en ? prdc_pkg::cross_t'(s2.px1) - prdc_pkg::cross_t'(s2.py1) : '0;
    cr2   = s2.e2_en ? prdc_pkg::cross_t'(s2.px2) - prdc_pkg::cross_t'(s2.py2) : '0;
    s3_next.dup_inc   = {1'b0, s2.dup1} + {1'b0, s2.dup2};
    s3_next.zero_inc  = {1'b0, zero1} + {1'b0, zero2};
    s3_next.area_d    = prdc_pkg::esum_t'(cr1) + prdc_pkg::esum_t'(cr2);
    s3_next.ends      = s2.ends;
    s3_next.last_poly = s2.last_poly;
    s3_next.ge3       = s2.ge3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v  <= 1'b0;
      out_v <= 1'b0;
    end else begin
      if (in_free) begin
        s2_v <= in_v;
      end
      if (s3_free) begin
        out_v <= s2_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_free && in_v) begin
      s2 <= s2_next;
    end
    if (s3_free && s2_v) begin
      out_d <= s3_next;
    end
  end

endmodule

/* src/prdc_ring_acc.sv */
module prdc_ring_acc (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_v,
  input  prdc_pkg::s3_t                      in_d,
  output logic                               in_free,
  input  prdc_pkg::limit_t                   area_limit,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [15:0] ring_duplicates, [31:16] ring_zero_edges, [32] ring_is_sliver,
  // [48:33] total_duplicates, [64:49] total_zero_edges, [80:65] total_slivers
  output logic [prdc_pkg::OUT_DATA_BITS-1:0] m_tdata,
  output logic                               m_tlast
);

  localparam int SUM_BITS = prdc_pkg::CNT_BITS + 1;

  prdc_pkg::cnt_t  dup_acc, zero_acc;
  prdc_pkg::area_t area_acc;
  prdc_pkg::cnt_t  tot_dup, tot_zero, tot_sliver;

  logic            ring_v;
  prdc_pkg::ring_t ring;
  prdc_pkg::ring_t ring_next;
  logic            out_free;

  logic [SUM_BITS-1:0] dup_sum, zero_sum;
  logic [SUM_BITS-1:0] td_sum, tz_sum, ts_sum;
  prdc_pkg::area_t     amag;
  logic                sliver;
  prdc_pkg::cnt_t      td_new, tz_new, ts_new;

  assign out_free = !m_tvalid || m_tready;
  assign in_free  = !ring_v || out_free;

  always_comb begin
    dup_sum  = {1'b0, dup_acc} + SUM_BITS'(in_d.dup_inc);
    zero_sum = {1'b0, zero_acc} + SUM_BITS'(in_d.zero_inc);
    ring_next.dups      = dup_sum[prdc_pkg::CNT_BITS] ? '1 : dup_sum[prdc_pkg::CNT_BITS-1:0];
    ring_next.zeros     = zero_sum[prdc_pkg::CNT_BITS] ? '1 : zero_sum[prdc_pkg::CNT_BITS-1:0];
    ring_next.area      = area_acc + prdc_pkg::AREA_BITS'(in_d.area_d);
    ring_next.last_poly = in_d.last_poly;
    ring_next.ge3       = in_d.ge3;
  end

  always_comb begin
    amag   = ring.area[prdc_pkg::AREA_BITS-1] ? (~ring.area + 1'b1) : ring.area;
    sliver = !ring.ge3 || (amag <= prdc_pkg::AREA_BITS'(area_limit));
    td_sum = {1'b0, tot_dup} + {1'b0, ring.dups};
    tz_sum = {1'b0, tot_zero} + {1'b0, ring.zeros};
    ts_sum = {1'b0, tot_sliver} + SUM_BITS'(sliver);
    td_new = td_sum[prdc_pkg::CNT_BITS] ? '1 : td_sum[prdc_pkg::CNT_BITS-1:0];
    tz_new = tz_sum[prdc_pkg::CNT_BITS] ? '1 : tz_sum[prdc_pkg::CNT_BITS-1:0];
    ts_new = ts_sum[prdc_pkg::CNT_BITS] ? '1 : ts_sum[prdc_pkg::CNT_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_v     <= 1'b0;
      m_tvalid   <= 1'b0;
      dup_acc    <= '0;
      zero_acc   <= '0;
      area_acc   <= '0;
      tot_dup    <= '0;
      tot_zero   <= '0;
      tot_sliver <= '0;
    end else begin
      if (in_free) begin
        ring_v <= in_v && in_d.ends;
        if (in_v) begin
          if (in_d.ends) begin
            dup_acc  <= '0;
            zero_acc <= '0;
            area_acc <= '0;
          end else begin
            dup_acc  <= ring_next.dups;
            zero_acc <= ring_next.zeros;
            area_acc <= ring_next.area;
          end
        end
      end
      if (out_free) begin
        m_tvalid <= ring_v;
        if (ring_v) begin
          if (ring.last_poly) begin
            tot_dup    <= '0;
            tot_zero   <= '0;
            tot_sliver <= '0;
          end else begin
            tot_dup    <= td_new;
            tot_zero   <= tz_new;
            tot_sliver <= ts_new;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_free && in_v && in_d.ends) begin
      ring <= ring_next;
    end
    if (out_free && ring_v) begin
      m_tdata <= {{prdc_pkg::OUT_PAD_BITS{1'b0}}, ts_new, tz_new, td_new, sliver,
                  ring.zeros, ring.dups};
      m_tlast <= ring.last_poly;
    end
  end

endmodule

/* src/polygon_ring_defect_counter_core.sv */
// A ring result appears on m_tvalid after the ring-ending vertex passes the pipeline.
// Throughput: one vertex item per cycle, set by the pipeline of intake register,
// multiplier stage, edge test stage and ring accumulator, followed by the output register.
// Stages stall from the output back while m_tready is low; empty stages still take items.
// Reset (rst, synchronous, active high) clears the pipeline, ring state, polygon totals
// and both limit registers.
module polygon_ring_defect_counter_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [23:0] vertex_x, [47:24] vertex_y
  input  logic [prdc_pkg::IN_DATA_BITS-1:0]  s_tdata,
  input  logic                               s_tlast,
  // [0] empty_ring, [1] last_in_polygon
  input  logic [prdc_pkg::USER_BITS-1:0]     s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [15:0] ring_duplicates, [31:16] ring_zero_edges, [32] ring_is_sliver,
  // [48:33] total_duplicates, [64:49] total_zero_edges, [80:65] total_slivers
  output logic [prdc_pkg::OUT_DATA_BITS-1:0] m_tdata,
  output logic                               m_tlast,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [prdc_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [prdc_pkg::CFG_DATA_BITS-1:0] pwdata,
  output logic [prdc_pkg::CFG_DATA_BITS-1:0] prdata,
  output logic                               pready
);

  prdc_pkg::limit_t edge_limit;
  prdc_pkg::limit_t area_limit;

  logic          s1_v;
  prdc_pkg::s1_t s1_d;
  logic          s2_free;
  logic          s3_v;
  prdc_pkg::s3_t s3_d;
  logic          acc_free;

  prdc_cfg_regs u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .edge_limit (edge_limit),
    .area_limit (area_limit)
  );

  prdc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .nxt_free (s2_free),
    .out_v    (s1_v),
    .out_d    (s1_d)
  );

  prdc_edge_math u_edge (
    .clk        (clk),
    .rst        (rst),
    .in_v       (s1_v),
    .in_d       (s1_d),
    .in_free    (s2_free),
    .edge_limit (edge_limit),
    .nxt_free   (acc_free),
    .out_v      (s3_v),
    .out_d      (s3_d)
  );

  prdc_ring_acc u_acc (
    .clk        (clk),
    .rst        (rst),
    .in_v       (s3_v),
    .in_d       (s3_d),
    .in_free    (acc_free),
    .area_limit (area_limit),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule
